// ===== rtl/mads_pkg.sv =====
// shared types and constants for the moving average deviation signal block
// no dependencies; imported by the checker and every rtl file but mads_ram
package mads_pkg;

    localparam int INSTR_W    = 16;
    localparam int PRICE_IN_W = 32;
    localparam int PRICE_W    = 33;
    localparam int ORDER_W    = 32;
    localparam int THR_W      = 16;
    localparam int FRAC_W     = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // input tdata: instrument, bid, ask, order number, order final
    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 1;
    // output tdata: signal instrument, price in half units
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    localparam int QDEPTH = 2;

    localparam logic [THR_W-1:0] THR_RESET = 16'd655;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_INSTRUMENT = 2'd1,
        CFG_THRESHOLD  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_ORDER = 1'b1
    } action_t;

    typedef enum logic {
        SIDE_BUY  = 1'b0,
        SIDE_SELL = 1'b1
    } side_t;

    typedef enum logic [1:0] {
        KIND_TICK_OWN   = 2'd0,
        KIND_TICK_OTHER = 2'd1,
        KIND_ORDER      = 2'd2
    } kind_t;

    // one classified item on its way from front to back
    typedef struct packed {
        kind_t              kind;
        logic [PRICE_W-1:0] data;
    } entry_t;

endpackage

// ===== rtl/moving_average_deviation_signal.sv =====
// a tick passes the queue, window update and test stages to the output register
// throughput: one item per cycle unless stalled, set by the running-sum update
//   against the price ring, whose registered read is fetched one slot ahead
// reset: rst_n asynchronous active low; window empty, sum zero, no order open,
//   block disabled, threshold 655; the ring itself is not cleared
module moving_average_deviation_signal #(
    parameter int WINDOW = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mads_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mads_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // instrument, bid, ask, order_number, order_final, zero pad
    input  logic [mads_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic [mads_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // signal_instrument, price_half_units, zero pad
    output logic [mads_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // side
    output logic [mads_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
    import mads_pkg::*;

    // configuration registers
    logic               enable_reg;
    logic [INSTR_W-1:0] watched_reg;
    logic [THR_W-1:0]   thr_reg;

    // unpacked input fields
    logic                  in_action;
    logic [INSTR_W-1:0]    in_instrument;
    logic [PRICE_IN_W-1:0] in_bid;
    logic [PRICE_IN_W-1:0] in_ask;
    logic [ORDER_W-1:0]    in_order_number;
    logic                  in_order_final;

    logic   in_accept;
    logic   push;
    entry_t push_entry;
    logic   q_ready;
    logic   q_valid;
    logic   q_pop;
    entry_t q_head;

    logic               res_valid;
    logic [INSTR_W-1:0] res_instr;
    logic               res_side;
    logic [PRICE_W-1:0] res_price;

    // configuration is always taken; unknown indexes are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            watched_reg <= '0;
            thr_reg     <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ENABLE:     enable_reg  <= cfg_data[0];
                CFG_INSTRUMENT: watched_reg <= cfg_data[INSTR_W-1:0];
                CFG_THRESHOLD:  thr_reg     <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // field layout of the input tdata, lowest bits first
    assign in_action       = s_axis_tuser[0];
    assign in_instrument   = s_axis_tdata[INSTR_W-1:0];
    assign in_bid          = s_axis_tdata[INSTR_W +: PRICE_IN_W];
    assign in_ask          = s_axis_tdata[INSTR_W+PRICE_IN_W +: PRICE_IN_W];
    assign in_order_number = s_axis_tdata[INSTR_W+2*PRICE_IN_W +: ORDER_W];
    assign in_order_final  = s_axis_tdata[INSTR_W+2*PRICE_IN_W+ORDER_W];

    // the queue decouples acceptance from the back end, so up to two more queued
    // items are still taken while a result waits on the output side
    assign s_axis_tready = q_ready;
    assign in_accept     = s_axis_tvalid && q_ready;

    // front end: disabled items and foreign order updates never enter the queue
    mads_front u_front (
        .accept            (in_accept),
        .enable            (enable_reg),
        .watched_instrument(watched_reg),
        .action            (in_action),
        .instrument        (in_instrument),
        .bid_px            (in_bid),
        .ask_px            (in_ask),
        .order_number      (in_order_number),
        .order_final       (in_order_final),
        .push              (push),
        .entry             (push_entry)
    );

    mads_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // back end: ring and running sum update, then a three stage test
    // (multiply, absolute difference, compare) into the output register
    mads_back #(
        .WINDOW(WINDOW)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_valid),
        .q_entry            (q_head),
        .q_pop              (q_pop),
        .watched_instrument (watched_reg),
        .deviation_threshold(thr_reg),
        .out_valid          (res_valid),
        .out_ready          (m_axis_tready),
        .signal_instrument  (res_instr),
        .side               (res_side),
        .price_half_units   (res_price)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-PRICE_W-INSTR_W){1'b0}}, res_price, res_instr};
    assign m_axis_tuser  = res_side;

endmodule

// ===== rtl/mads_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
module mads_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mads_front.sv =====
// front end: classifies accepted items and builds queue entries
// depends on mads_pkg
module mads_front (
    input  logic                            accept,
    input  logic                            enable,
    input  logic [mads_pkg::INSTR_W-1:0]    watched_instrument,
    input  logic                            action,
    input  logic [mads_pkg::INSTR_W-1:0]    instrument,
    input  logic [mads_pkg::PRICE_IN_W-1:0] bid_px,
    input  logic [mads_pkg::PRICE_IN_W-1:0] ask_px,
    input  logic [mads_pkg::ORDER_W-1:0]    order_number,
    input  logic                            order_final,
    output logic                            push,
    output mads_pkg::entry_t                entry
);
    import mads_pkg::*;

    logic               own;
    logic [PRICE_W-1:0] mid;
    logic               idle_next;

    assign own       = (instrument == watched_instrument);
    assign mid       = {1'b0, bid_px} + {1'b0, ask_px};
    assign idle_next = order_final || (order_number == '0);

    always_comb
    begin
        push       = 1'b0;
        entry.kind = KIND_TICK_OTHER;
        entry.data = mid;
        if (accept && enable)
        begin
            if (action == ACT_ORDER)
            begin
                // order updates for other instruments are dropped here
                if (own)
                begin
                    push       = 1'b1;
                    entry.kind = KIND_ORDER;
                    entry.data = {{(PRICE_W-1){1'b0}}, idle_next};
                end
            end
            else
            begin
                push       = 1'b1;
                entry.kind = own ? KIND_TICK_OWN : KIND_TICK_OTHER;
            end
        end
    end

endmodule

// ===== rtl/mads_queue.sv =====
// short fifo between the front end and the back end
// depends on mads_pkg
module mads_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mads_pkg::entry_t push_entry,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output mads_pkg::entry_t head
);
    import mads_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

    entry_t           q_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready = (count_reg != CNT_FULL);
    assign valid = (count_reg != '0);
    assign head  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/mads_back.sv =====
// back end: window update, deviation test pipeline and output register
// depends on mads_pkg and mads_ram
module mads_back #(
    parameter int WINDOW = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  mads_pkg::entry_t             q_entry,
    output logic                         q_pop,
    input  logic [mads_pkg::INSTR_W-1:0] watched_instrument,
    input  logic [mads_pkg::THR_W-1:0]   deviation_threshold,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mads_pkg::INSTR_W-1:0] signal_instrument,
    output logic                         side,
    output logic [mads_pkg::PRICE_W-1:0] price_half_units
);
    import mads_pkg::*;

    localparam int PTR_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = PRICE_W + CNT_W;
    localparam int PROD_W = PRICE_W + CNT_W;
    localparam int LHS_W  = PROD_W + FRAC_W;
    localparam int RHS_W  = THR_W + SUM_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(2);

    // window state
    logic [PTR_W-1:0]   wp_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [PRICE_W-1:0] newest_reg;
    logic               idle_reg;

    // test pipeline
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic [PROD_W-1:0]  s2_scaled_reg;
    logic [RHS_W-1:0]   s2_rhs_reg;
    logic [SUM_W-1:0]   s2_sum_reg;
    logic [PRICE_W-1:0] s2_price_reg;
    logic               s3_valid_reg;
    logic [PROD_W-1:0]  s3_diff_reg;
    logic               s3_above_reg;
    logic [RHS_W-1:0]   s3_rhs_reg;
    logic [PRICE_W-1:0] s3_price_reg;

    // output register
    logic               out_valid_reg;
    logic [INSTR_W-1:0] out_instr_reg;
    logic               out_side_reg;
    logic [PRICE_W-1:0] out_price_reg;

    logic               adv;
    logic               tick_own;
    logic               order_upd;
    logic               full;
    logic [PTR_W-1:0]   wp_next;
    logic [PTR_W-1:0]   raddr;
    logic [PRICE_W-1:0] oldest;
    logic [SUM_W-1:0]   sum_next;
    logic               s1_ok;
    logic [PROD_W-1:0]  s2_sum_ext;
    logic               s2_above;
    logic [CMP_W-1:0]   lhs;
    logic [CMP_W-1:0]   rhs;

    // the whole back end moves unless a result waits at the output
    assign adv       = !out_valid_reg || out_ready;
    assign q_pop     = adv && q_valid;
    assign tick_own  = q_pop && (q_entry.kind == KIND_TICK_OWN);
    assign order_upd = q_pop && (q_entry.kind == KIND_ORDER);
    assign full      = (fill_reg == CNT_FULL);
    assign wp_next   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    // read address runs one slot ahead so the oldest price is ready next time
    assign raddr     = tick_own ? wp_next : wp_reg;
    assign sum_next  = sum_reg + SUM_W'(q_entry.data)
                       - (full ? SUM_W'(oldest) : '0);

    mads_ram #(
        .WIDTH(PRICE_W),
        .DEPTH(WINDOW)
    ) u_ring (
        .clk  (clk),
        .we   (tick_own),
        .waddr(wp_reg),
        .wdata(q_entry.data),
        .raddr(raddr),
        .rdata(oldest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            newest_reg    <= '0;
            idle_reg      <= 1'b1;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= q_pop && (q_entry.kind != KIND_ORDER);
            if (tick_own)
            begin
                wp_reg     <= wp_next;
                sum_reg    <= sum_next;
                newest_reg <= q_entry.data;
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (order_upd)
            begin
                idle_reg <= q_entry.data[0];
            end
            s2_valid_reg  <= s1_valid_reg && s1_ok;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg && (lhs > rhs);
        end
    end

    // stage one reads the window state as left by its own item
    assign s1_ok = (fill_reg >= CNT_MIN) && idle_reg && (sum_reg != '0);

    assign s2_sum_ext = PROD_W'(s2_sum_reg);
    assign s2_above   = (s2_scaled_reg > s2_sum_ext);

    assign lhs = CMP_W'({s3_diff_reg, {FRAC_W{1'b0}}});
    assign rhs = CMP_W'(s3_rhs_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_scaled_reg <= PROD_W'(newest_reg) * PROD_W'(fill_reg);
            s2_rhs_reg    <= RHS_W'(deviation_threshold) * RHS_W'(sum_reg);
            s2_sum_reg    <= sum_reg;
            s2_price_reg  <= newest_reg;
            s3_diff_reg   <= s2_above ? s2_scaled_reg - s2_sum_ext
                                      : s2_sum_ext - s2_scaled_reg;
            s3_above_reg  <= s2_above;
            s3_rhs_reg    <= s2_rhs_reg;
            s3_price_reg  <= s2_price_reg;
            out_instr_reg <= watched_instrument;
            out_side_reg  <= s3_above_reg ? SIDE_SELL : SIDE_BUY;
            out_price_reg <= s3_price_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign signal_instrument = out_instr_reg;
    assign side              = out_side_reg;
    assign price_half_units  = out_price_reg;

endmodule

// ===== rtl/mads_checker.sv =====
// port level checks for the moving average deviation signal block
// depends on mads_pkg; bound to the top level at the end of this file
module mads_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mads_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [mads_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import mads_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no result in the cycle after reset is seen low
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // a sell means the price is above a mean of non-negative prices
    a_sell_price: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == SIDE_SELL) |->
            m_axis_tdata[INSTR_W +: PRICE_W] != '0)
        else $error("sell signal with zero price");

    // once the output side has moved, the queue has room
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && !m_axis_tready) |=> s_axis_tready)
        else $error("input stalled although output was flowing");

endmodule

bind moving_average_deviation_signal mads_checker u_mads_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
